### rtl/i2c_ram_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2c_ram_pkg;

  localparam int unsigned BurstLen = 6;

  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PhIdle      = 4'd0;
  localparam logic [PhaseW-1:0] PhStartHi   = 4'd1;
  localparam logic [PhaseW-1:0] PhStartFall = 4'd2;
  localparam logic [PhaseW-1:0] PhTxLow     = 4'd3;
  localparam logic [PhaseW-1:0] PhTxHigh    = 4'd4;
  localparam logic [PhaseW-1:0] PhTxAckLow  = 4'd5;
  localparam logic [PhaseW-1:0] PhTxAckHigh = 4'd6;
  localparam logic [PhaseW-1:0] PhRsLow     = 4'd7;
  localparam logic [PhaseW-1:0] PhRxLow     = 4'd8;
  localparam logic [PhaseW-1:0] PhRxHigh    = 4'd9;
  localparam logic [PhaseW-1:0] PhRxAckLow  = 4'd10;
  localparam logic [PhaseW-1:0] PhRxAckHigh = 4'd11;
  localparam logic [PhaseW-1:0] PhStopLow   = 4'd12;
  localparam logic [PhaseW-1:0] PhStopHigh  = 4'd13;
  localparam logic [PhaseW-1:0] PhStopRise  = 4'd14;

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncBurst = 2'd2;
  localparam logic [1:0] FuncNone  = 2'd3;

  localparam logic [1:0] RegDevAddr    = 2'd0;
  localparam logic [1:0] RegHalfPeriod = 2'd1;

  localparam logic [7:0] DevAddrReset    = 8'hA6;
  localparam logic [7:0] HalfPeriodReset = 8'h01;

  // scl, sda_out, sda_drive
  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  typedef struct packed {
    lines_t     lines;
    logic       busy;
    logic       dv;
    logic [7:0] rb;
    logic       lb;
  } result_t;

endpackage

`default_nettype wire

### rtl/i2c_register_access_master.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: reg_addr, wr_data, sda_in
//                                             tuser: cmd_valid, func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: scl, sda_out, sda_drive,
//                                             busy_res, read_byte
//                                             tuser: data_valid, tlast: last_byte
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One tick beat in, one result beat out; a beat is taken every cycle while the skid entry is empty.
// The sequencer state advances in the cycle a tick beat is accepted; the result
// is registered into the output register, or into the skid while that register is held.
// A two-entry output buffer (output register plus skid) keeps input ready while
// one result waits; input stalls only when both entries are full.
// Reset puts the bus idle with scl and sda high, driven; config takes its
// reset values. Config writes are always ready.

module i2c_register_access_master
  import i2c_ram_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] reg_addr, [15:8] wr_data, [16] sda_in, [23:17] zero
  input  wire logic [23:0] s_axis_tdata,
  // [0] cmd_valid, [2:1] func
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] scl, [1] sda_out, [2] sda_drive, [3] busy_res, [11:4] read_byte,
  // [15:12] zero
  output logic [15:0]      m_axis_tdata,
  // [0] data_valid
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic [7:0]        dev_addr_q;
  logic [7:0]        half_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [3:0]        bit_q, bit_d;
  logic [2:0]        byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        delay_q, delay_d;
  logic [1:0]        func_q, func_d;
  logic [7:0]        reg_q, reg_d;
  logic [7:0]        wrd_q, wrd_d;
  lines_t            lines_q, lines_d;
  result_t           res_d, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              in_acc, out_take, entered;
  logic [3:0]        bit_inc;
  logic [7:0]        rx_shift;

  logic       cmd_valid;
  logic [1:0] func_in;
  logic [7:0] reg_in;
  logic [7:0] wrd_in;
  logic       sda_in;

  assign cmd_valid = s_axis_tuser[0];
  assign func_in   = s_axis_tuser[2:1];
  assign reg_in    = s_axis_tdata[7:0];
  assign wrd_in    = s_axis_tdata[15:8];
  assign sda_in    = s_axis_tdata[16];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  function automatic lines_t lines_of(input logic scl, input logic sda, input logic drv);
    lines_t l;
    l.scl = scl;
    l.sda = drv ? sda : 1'b1;
    l.drv = drv;
    return l;
  endfunction

  function automatic logic last_read(input logic [1:0] func, input logic [2:0] bytes);
    logic [3:0] total;
    total = (func == FuncRead) ? 4'd1 : 4'(BurstLen);
    return ({1'b0, bytes} + 4'd1) >= total;
  endfunction

  function automatic lines_t show(input logic [PhaseW-1:0] ph, input logic msb,
                                  input logic ackv);
    lines_t l;
    case (ph)
      PhStartHi:   l = lines_of(1'b1, 1'b1, 1'b1);
      PhStartFall: l = lines_of(1'b1, 1'b0, 1'b1);
      PhTxLow:     l = lines_of(1'b0, msb, 1'b1);
      PhTxHigh:    l = lines_of(1'b1, msb, 1'b1);
      PhTxAckLow:  l = lines_of(1'b0, 1'b1, 1'b0);
      PhTxAckHigh: l = lines_of(1'b1, 1'b1, 1'b0);
      PhRsLow:     l = lines_of(1'b0, 1'b1, 1'b1);
      PhRxLow:     l = lines_of(1'b0, 1'b1, 1'b0);
      PhRxHigh:    l = lines_of(1'b1, 1'b1, 1'b0);
      PhRxAckLow:  l = lines_of(1'b0, ackv, 1'b1);
      PhRxAckHigh: l = lines_of(1'b1, ackv, 1'b1);
      PhStopLow:   l = lines_of(1'b0, 1'b0, 1'b1);
      PhStopHigh:  l = lines_of(1'b1, 1'b0, 1'b1);
      PhStopRise:  l = lines_of(1'b1, 1'b1, 1'b1);
      default:     l = lines_of(1'b1, 1'b1, 1'b1);
    endcase
    return l;
  endfunction

  assign bit_inc  = bit_q + 4'd1;
  assign rx_shift = {shift_q[6:0], sda_in};

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    delay_d = delay_q;
    func_d  = func_q;
    reg_d   = reg_q;
    wrd_d   = wrd_q;
    lines_d = lines_q;
    entered = 1'b0;
    res_d.dv = 1'b0;
    res_d.rb = 8'd0;
    res_d.lb = 1'b0;

    if (phase_q == PhIdle) begin
      if (cmd_valid && func_in != FuncNone) begin
        func_d  = func_in;
        reg_d   = reg_in;
        wrd_d   = wrd_in;
        byte_d  = 3'd0;
        bit_d   = 4'd0;
        shift_d = 8'd0;
        phase_d = PhStartHi;
        entered = 1'b1;
      end
    end else if (delay_q != 8'd0) begin
      delay_d = delay_q - 8'd1;
    end else begin
      entered = 1'b1;
      case (phase_q)
        PhStartHi: phase_d = PhStartFall;
        PhStartFall: begin
          shift_d = (byte_q == 3'd0) ? dev_addr_q : dev_addr_q + 8'd1;
          bit_d   = 4'd0;
          phase_d = PhTxLow;
        end
        PhTxLow: phase_d = PhTxHigh;
        PhTxHigh: begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          phase_d = (bit_inc >= 4'd8) ? PhTxAckLow : PhTxLow;
        end
        PhTxAckLow: phase_d = PhTxAckHigh;
        PhTxAckHigh: begin
          bit_d = 4'd0;
          if (byte_q == 3'd0) begin
            byte_d  = 3'd1;
            shift_d = reg_q;
            phase_d = PhTxLow;
          end else if (byte_q == 3'd1) begin
            byte_d = 3'd2;
            if (func_q == FuncWrite) begin
              shift_d = wrd_q;
              phase_d = PhTxLow;
            end else begin
              phase_d = PhRsLow;
            end
          end else if (byte_q == 3'd2 && func_q != FuncWrite) begin
            byte_d  = 3'd0;
            shift_d = 8'd0;
            phase_d = PhRxLow;
          end else begin
            phase_d = PhStopLow;
          end
        end
        PhRsLow: phase_d = PhStartHi;
        PhRxLow: phase_d = PhRxHigh;
        PhRxHigh: begin
          shift_d = rx_shift;
          bit_d   = bit_inc;
          if (bit_inc >= 4'd8) begin
            res_d.dv = 1'b1;
            res_d.rb = rx_shift;
            res_d.lb = last_read(func_q, byte_q);
            phase_d  = PhRxAckLow;
          end else begin
            phase_d = PhRxLow;
          end
        end
        PhRxAckLow: phase_d = PhRxAckHigh;
        PhRxAckHigh: begin
          if (last_read(func_q, byte_q)) begin
            phase_d = PhStopLow;
          end else begin
            byte_d  = byte_q + 3'd1;
            bit_d   = 4'd0;
            shift_d = 8'd0;
            phase_d = PhRxLow;
          end
        end
        PhStopLow:  phase_d = PhStopHigh;
        PhStopHigh: phase_d = PhStopRise;
        default: begin
          entered = 1'b0;
          phase_d = PhIdle;
          delay_d = 8'd0;
          lines_d = lines_of(1'b1, 1'b1, 1'b1);
        end
      endcase
    end

    if (entered) begin
      delay_d = (half_q == 8'd0) ? 8'd0 : half_q - 8'd1;
      lines_d = show(phase_d, shift_d[7], last_read(func_d, byte_d));
    end

    res_d.lines = lines_d;
    res_d.busy  = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
      half_q     <= HalfPeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDevAddr:    dev_addr_q <= cfg_data_i;
        RegHalfPeriod: half_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bit_q   <= 4'd0;
      byte_q  <= 3'd0;
      shift_q <= 8'd0;
      delay_q <= 8'd0;
      func_q  <= FuncWrite;
      reg_q   <= 8'd0;
      wrd_q   <= 8'd0;
      lines_q <= lines_of(1'b1, 1'b1, 1'b1);
    end else if (in_acc) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      delay_q <= delay_d;
      func_q  <= func_d;
      reg_q   <= reg_d;
      wrd_q   <= wrd_d;
      lines_q <= lines_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.rb, out_q.busy, out_q.lines.drv, out_q.lines.sda,
                          out_q.lines.scl};
  assign m_axis_tuser  = out_q.dv;
  assign m_axis_tlast  = out_q.lb;

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> lines_q == lines_of(1'b1, 1'b1, 1'b1))
    else $error("idle bus not released high");

  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lines_q.drv |-> lines_q.sda)
    else $error("released sda not reading high");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register empty");

  a_rx_byte_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_d.dv |=> phase_q == PhRxAckLow && lines_q.drv)
    else $error("received byte not followed by master ack");

endmodule

`default_nettype wire
